### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the transcoder top module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/pmst_pkg.sv
// ----------------------------------------------------------------------------
// pmst_pkg
// shared types and constants of the packed midi to smf track transcoder
// ----------------------------------------------------------------------------
package pmst_pkg;

  localparam logic [2:0] PH_DELTA = 3'd0;
  localparam logic [2:0] PH_STATUS = 3'd1;
  localparam logic [2:0] PH_DATA1 = 3'd2;
  localparam logic [2:0] PH_DATA2 = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;
  localparam logic [2:0] PH_FAIL = 3'd5;

  localparam logic [27:0] DELTA_MAX = 28'hFFFFFFF;
  localparam logic [7:0] DELTA_STEP = 8'd240;
  localparam logic [7:0] BYTE_TICK = 8'hF8;
  localparam logic [7:0] BYTE_END = 8'hFC;
  localparam logic [3:0] HI_NOTE_ON = 4'h9;
  localparam logic [3:0] HI_CONTROL = 4'hB;
  localparam logic [3:0] HI_PATCH = 4'hC;
  localparam logic [3:0] HI_PITCH = 4'hE;
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [7:0] META_MARK = 8'hFF;
  localparam logic [7:0] META_TRACK_END = 8'h2F;

  localparam int unsigned REC_BYTES = 7;

  typedef struct packed {
    logic [REC_BYTES-1:0][7:0] data;
    logic [2:0] count;
    logic corrupt;
  } rec_t;

endpackage

### hdl/packed_midi_to_smf_track_transcoder.sv
// ----------------------------------------------------------------------------
// packed_midi_to_smf_track_transcoder
// packed game midi byte stream in, standard midi track body bytes out
// ----------------------------------------------------------------------------
// input stream s_axis: one packed byte per transfer, tuser high restarts the
// parse (mode, delta and held data cleared) before the byte is handled.
// output stream m_axis: one track byte per transfer, tuser marks an error
// byte (data 0), tlast marks the final byte produced by one input byte.
// cfg: write of voice_channel, always ready; write it only while idle.
// bytes that finish an event load a record of 1 to 7 bytes, and the first
// output byte is valid the next cycle. the output register sends one byte
// per cycle while the receiver is ready; after an event of n output bytes
// the next input byte is taken with the last output byte; bytes that produce
// no output pass at one per cycle while the output is empty or sends its
// last byte.
// when the receiver stalls, the record is held and s_axis_tready stays low
// until the last byte of the record is transferred.
// reset clears the parse state, voice_channel and the output valid and index.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module packed_midi_to_smf_track_transcoder import pmst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte
  input  logic       s_axis_tuser,   // start_of_stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte
  output logic       m_axis_tuser,   // corrupt
  output logic       m_axis_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

  logic [3:0] voice_channel;
  logic       accept;
  logic       emit;
  rec_t       rec;
  logic       free;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = free;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_channel <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      voice_channel <= cfg_data;
    end
  end

  pmst_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .in_byte         (s_axis_tdata),
    .start_of_stream (s_axis_tuser),
    .voice_channel   (voice_channel),
    .emit            (emit),
    .rec             (rec)
  );

  pmst_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .load        (emit),
    .rec_in      (rec),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_byte    (m_axis_tdata),
    .out_corrupt (m_axis_tuser),
    .out_last    (m_axis_tlast),
    .free        (free)
  );

  `ASSERT_CLK(a_in_only_at_record_end, clk, rst, (s_axis_tready && m_axis_tvalid) |-> (m_axis_tready && m_axis_tlast), "input taken while a record is still pending")
  `ASSERT_CLK(a_error_byte_form, clk, rst, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'h00 && m_axis_tlast), "error byte is not a single zero byte")
  `ASSERT_ALWAYS(a_idle_after_reset, clk, $past(rst) |-> !m_axis_tvalid, "output valid right after reset")

endmodule

### hdl/pmst_parser.sv
// ----------------------------------------------------------------------------
// pmst_parser
// parse state of the packed event stream and the output record of one byte
// ----------------------------------------------------------------------------
module pmst_parser import pmst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       start_of_stream,
  input  logic [3:0] voice_channel,
  output logic       emit,
  output rec_t       rec
);

  logic [2:0]  phase, phase_next;
  logic [7:0]  running_status, running_status_next;
  logic [27:0] delta_ticks, delta_ticks_next;
  logic [7:0]  first_data, first_data_next;

  logic [2:0]  cur_phase;
  logic [7:0]  cur_status;
  logic [27:0] cur_delta;
  logic [7:0]  cur_first;
  logic [7:0]  amount;
  logic [28:0] sum;
  logic        ev;
  logic        ev_event;
  logic        ev_fail;
  logic        ev_eot;
  logic [7:0]  d1, d2;
  logic        two;
  logic [7:0]  status_out;
  logic [2:0]  ng;
  logic [31:0] vlq_vec;
  logic [23:0] tail;
  logic        mode_byte;

  always_comb begin
    cur_phase = start_of_stream ? PH_DELTA : phase;
    cur_status = start_of_stream ? 8'h00 : running_status;
    cur_delta = start_of_stream ? 28'd0 : delta_ticks;
    cur_first = start_of_stream ? 8'h00 : first_data;

    amount = (in_byte == BYTE_TICK) ? DELTA_STEP : in_byte;
    sum = {1'b0, cur_delta} + {21'd0, amount};
    mode_byte = (in_byte[7:4] == HI_NOTE_ON) || (in_byte[7:4] == HI_CONTROL) ||
                (in_byte[7:4] == HI_PATCH) || (in_byte[7:4] == HI_PITCH);

    phase_next = cur_phase;
    running_status_next = cur_status;
    delta_ticks_next = cur_delta;
    first_data_next = cur_first;
    ev_event = 1'b0;
    ev_fail = 1'b0;
    ev_eot = 1'b0;
    d1 = in_byte;
    d2 = 8'h00;
    two = 1'b0;

    case (cur_phase)
      PH_DELTA: begin
        delta_ticks_next = sum[28] ? DELTA_MAX : sum[27:0];
        if (in_byte != BYTE_TICK) begin
          phase_next = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (mode_byte) begin
          if (in_byte[3:0] != voice_channel) begin
            ev_fail = 1'b1;
          end else begin
            running_status_next = in_byte;
            phase_next = PH_DATA1;
          end
        end else if (in_byte == BYTE_END) begin
          ev_eot = 1'b1;
          delta_ticks_next = 28'd0;
          phase_next = PH_DONE;
        end else if (cur_status == 8'h00) begin
          ev_fail = 1'b1;
        end else if (cur_status[7:4] == HI_PATCH) begin
          ev_event = 1'b1;
        end else begin
          first_data_next = in_byte;
          phase_next = PH_DATA2;
        end
      end
      PH_DATA1: begin
        if (cur_status[7:4] == HI_PATCH) begin
          ev_event = 1'b1;
        end else begin
          first_data_next = in_byte;
          phase_next = PH_DATA2;
        end
      end
      PH_DATA2: begin
        ev_event = 1'b1;
        d1 = cur_first;
        d2 = in_byte;
        two = 1'b1;
      end
      default: begin
      end
    endcase

    if (ev_fail) begin
      phase_next = PH_FAIL;
    end
    if (ev_event) begin
      delta_ticks_next = 28'd0;
      first_data_next = 8'h00;
      phase_next = PH_DELTA;
    end

    // event record: vlq delta, status, data bytes
    status_out = cur_status;
    if ((cur_status[7:4] == HI_NOTE_ON) && two && (d2 == 8'h00)) begin
      status_out = {HI_NOTE_OFF, voice_channel};
    end
    if (cur_delta >= 28'd2097152) begin
      ng = 3'd4;
      vlq_vec = {1'b0, cur_delta[6:0], 1'b1, cur_delta[13:7],
                 1'b1, cur_delta[20:14], 1'b1, cur_delta[27:21]};
    end else if (cur_delta >= 28'd16384) begin
      ng = 3'd3;
      vlq_vec = {8'h00, 1'b0, cur_delta[6:0], 1'b1, cur_delta[13:7],
                 1'b1, cur_delta[20:14]};
    end else if (cur_delta >= 28'd128) begin
      ng = 3'd2;
      vlq_vec = {16'h0000, 1'b0, cur_delta[6:0], 1'b1, cur_delta[13:7]};
    end else begin
      ng = 3'd1;
      vlq_vec = {24'h000000, 1'b0, cur_delta[6:0]};
    end
    tail = {d2, d1, status_out};

    ev = ev_event || ev_fail || ev_eot;
    rec.corrupt = ev_fail;
    if (ev_fail) begin
      rec.data = '0;
      rec.count = 3'd1;
    end else if (ev_eot) begin
      rec.data = {24'h000000, 8'h00, META_TRACK_END, META_MARK, 8'h00};
      rec.count = 3'd4;
    end else begin
      rec.data = {24'h000000, vlq_vec} | ({32'h00000000, tail} << {ng, 3'b000});
      rec.count = ng + 3'd2 + {2'b00, two};
    end
  end

  assign emit = accept && ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DELTA;
      running_status <= 8'h00;
      delta_ticks <= 28'd0;
      first_data <= 8'h00;
    end else if (accept) begin
      phase <= phase_next;
      running_status <= running_status_next;
      delta_ticks <= delta_ticks_next;
      first_data <= first_data_next;
    end
  end

endmodule

### hdl/pmst_serializer.sv
// ----------------------------------------------------------------------------
// pmst_serializer
// output record register, sends the bytes of one record one per transfer
// ----------------------------------------------------------------------------
module pmst_serializer import pmst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  rec_t       rec_in,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_corrupt,
  output logic       out_last,
  output logic       free
);

  logic       valid;
  rec_t       rec;
  logic [2:0] idx;
  logic       fire;

  assign out_valid = valid;
  assign out_byte = (idx < 3'(REC_BYTES)) ? rec.data[idx] : 8'h00;
  assign out_corrupt = rec.corrupt;
  assign out_last = (idx == (rec.count - 3'd1));
  assign fire = valid && out_ready;
  assign free = !valid || (fire && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx <= 3'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx <= 3'd0;
    end else if (fire) begin
      if (out_last) begin
        valid <= 1'b0;
        idx <= 3'd0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec <= rec_in;
    end
  end

endmodule

### tb/packed_midi_to_smf_track_transcoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_midi_to_smf_track_transcoder_tb
// self-checking bench: packed midi bytes in, track body bytes checked out
// ----------------------------------------------------------------------------
// each byte accepted on s_axis is run through a local model of the parser
// (delta ticks, running status, held data, voice channel), which queues the
// track bytes it should produce; every byte leaving m_axis is compared with
// the head of that queue. directed tests cover the event kinds, delta
// encoding boundaries, errors and channel settings; random events then run
// behind one long receiver hold-off without gaps, and a random phase follows
// with mostly well-formed events and some noise, random gaps on both streams in 3 of 4 passes.
// ----------------------------------------------------------------------------
module packed_midi_to_smf_track_transcoder_tb;
  import pmst_pkg::*;

  localparam logic [27:0] TICK_LIMIT = 28'hFFF_FFFF;
  localparam int unsigned RANDOM_ITEMS = 128;

  typedef struct packed {
    logic [7:0] data;
    logic corrupt;
    logic last;
  } track_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;   // in_byte
  logic s_axis_tuser = 1'b0;         // start_of_stream
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // out_byte
  logic m_axis_tuser;                // corrupt
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = 4'd0;

  // model state
  logic [2:0] strm_phase = PH_DELTA;
  logic [7:0] mode_byte = 8'd0;
  logic [27:0] tick_acc = 28'd0;
  logic [7:0] held_byte = 8'd0;
  logic [3:0] voice_ch = 4'd0;

  track_byte_t track_q[$];
  int unsigned mismatches = 0;
  int unsigned live_items = 0;
  int hold_cycles = 0;
  int rx_stall = 0;
  bit jitter_on = 1'b1;

  packed_midi_to_smf_track_transcoder DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #60_000_000;
    $display("packed_midi_to_smf_track_transcoder_tb NOT OK");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------- model ----------------
  function automatic void push_track_byte(logic [7:0] b, logic last);
    track_byte_t t;
    t.data = b;
    t.corrupt = 1'b0;
    t.last = last;
    track_q.push_back(t);
  endfunction

  function automatic void corrupt_byte();
    track_byte_t t;
    t.data = 8'd0;
    t.corrupt = 1'b1;
    t.last = 1'b1;
    track_q.push_back(t);
    strm_phase = PH_FAIL;
  endfunction

  function automatic void add_ticks(logic [31:0] amount);
    logic [31:0] room;
    room = {4'd0, TICK_LIMIT} - {4'd0, tick_acc};
    if (amount > room) tick_acc = TICK_LIMIT;
    else tick_acc = tick_acc + amount[27:0];
  endfunction

  function automatic void push_delta_vlq(logic [27:0] v);
    int groups;
    logic [7:0] b;
    groups = 1;
    if (v >= 28'd128) groups = 2;
    if (v >= 28'd16384) groups = 3;
    if (v >= 28'd2097152) groups = 4;
    for (int g = groups - 1; g >= 0; g--) begin
      b = {1'b0, 7'((v >> (7 * g)) & 28'h7F)};
      if (g > 0) b[7] = 1'b1;
      push_track_byte(b, 1'b0);
    end
  endfunction

  function automatic void close_event(logic [7:0] d1, logic [7:0] d2, logic two);
    logic [7:0] st;
    st = mode_byte;
    if (st[7:4] == HI_NOTE_ON && two && d2 == 8'd0) st = {HI_NOTE_OFF, voice_ch};
    push_delta_vlq(tick_acc);
    push_track_byte(st, 1'b0);
    push_track_byte(d1, !two);
    if (two) push_track_byte(d2, 1'b1);
    tick_acc = 28'd0;
    held_byte = 8'd0;
    strm_phase = PH_DELTA;
  endfunction

  function automatic void take_first_data(logic [7:0] b);
    if (mode_byte[7:4] == HI_PATCH) begin
      close_event(b, 8'd0, 1'b0);
    end else begin
      held_byte = b;
      strm_phase = PH_DATA2;
    end
  endfunction

  function automatic logic is_mode(logic [7:0] b);
    return b[7:4] == HI_NOTE_ON || b[7:4] == HI_CONTROL ||
           b[7:4] == HI_PATCH || b[7:4] == HI_PITCH;
  endfunction

  function automatic void predict_track_bytes(logic [7:0] b, logic sos);
    if (sos) begin
      strm_phase = PH_DELTA;
      mode_byte = 8'd0;
      tick_acc = 28'd0;
      held_byte = 8'd0;
    end
    case (strm_phase)
      PH_DELTA: begin
        if (b == BYTE_TICK) begin
          add_ticks(32'(DELTA_STEP));
        end else begin
          add_ticks(32'(b));
          strm_phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (is_mode(b)) begin
          if (b[3:0] != voice_ch) begin
            corrupt_byte();
          end else begin
            mode_byte = b;
            strm_phase = PH_DATA1;
          end
        end else if (b == BYTE_END) begin
          push_track_byte(8'h00, 1'b0);
          push_track_byte(META_MARK, 1'b0);
          push_track_byte(META_TRACK_END, 1'b0);
          push_track_byte(8'h00, 1'b1);
          tick_acc = 28'd0;
          strm_phase = PH_DONE;
        end else if (mode_byte == 8'd0) begin
          corrupt_byte();
        end else begin
          take_first_data(b);
        end
      end
      PH_DATA1: take_first_data(b);
      PH_DATA2: close_event(held_byte, b, 1'b1);
      default: ;
    endcase
  endfunction

  // ---------------- output side ----------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (!jitter_on) begin
        m_axis_tready <= 1'b1;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        rx_stall = gap_len();
        if (rx_stall == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          rx_stall--;
        end
      end
    end
  end

  always @(posedge clk) begin : check_track
    track_byte_t want;
    track_byte_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.data = m_axis_tdata;
      got.corrupt = m_axis_tuser;
      got.last = m_axis_tlast;
      if (track_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected byte data=%h corrupt=%b last=%b", $time,
                   got.data, got.corrupt, got.last);
      end else begin
        want = track_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: exp data=%h corrupt=%b last=%b, got data=%h corrupt=%b last=%b",
                     $time, want.data, want.corrupt, want.last,
                     got.data, got.corrupt, got.last);
        end
      end
    end
  end

  // ---------------- input side ----------------
  task automatic send_byte(input logic [7:0] b, input logic sos);
    int gap;
    gap = jitter_on ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= sos;
    do @(posedge clk); while (!s_axis_tready);
    if (sos || (strm_phase != PH_DONE && strm_phase != PH_FAIL)) live_items++;
    predict_track_bytes(b, sos);
  endtask

  task automatic send_delta(input int unsigned ticks, input logic sos);
    int unsigned n;
    logic s;
    n = ticks / 240;
    s = sos;
    for (int unsigned i = 0; i < n; i++) begin
      send_byte(BYTE_TICK, s);
      s = 1'b0;
    end
    send_byte(8'(ticks % 240), s);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (track_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_channel(input logic [3:0] ch);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= ch;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    voice_ch = ch;
  endtask

  function automatic logic [7:0] pick_mode();
    case ($urandom_range(0, 3))
      0: return {HI_NOTE_ON, 4'h0};
      1: return {HI_CONTROL, 4'h0};
      2: return {HI_PATCH, 4'h0};
      default: return {HI_PITCH, 4'h0};
    endcase
  endfunction

  // one event with random content; sos rides on its first byte
  task automatic send_random_event(input logic sos);
    logic s;
    logic [7:0] v;
    logic [7:0] st;
    int p;
    s = sos;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        send_byte(BYTE_TICK, s);
        s = 1'b0;
      end
    end
    v = 8'($urandom_range(0, 255));
    if (v == BYTE_TICK) v = 8'($urandom_range(0, 127));
    send_byte(v, s);
    p = $urandom_range(0, 99);
    if (p < 4) begin
      send_byte(BYTE_END, 1'b0);
      return;
    end
    if (mode_byte == 8'd0 || p < 50) begin
      st = pick_mode();
      st[3:0] = (p % 17 == 0) ? voice_ch + 4'($urandom_range(1, 15)) : voice_ch;
      send_byte(st, 1'b0);
      if (strm_phase == PH_FAIL) return;
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_byte(8'($urandom_range(0, 127)), 1'b0);
    end
    if (strm_phase == PH_DATA2) begin
      v = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      send_byte(v, 1'b0);
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_event_kinds();
    // channel still at its reset value
    send_byte(8'h00, 1'b1);
    send_byte({HI_NOTE_ON, 4'h0}, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h00, 1'b0);   // velocity zero
    send_byte(8'h80, 1'b0);
    send_byte({HI_CONTROL, 4'h0}, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h64, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte({HI_PATCH, 4'h0}, 1'b0);
    send_byte(BYTE_END, 1'b0);  // data position, taken as data
    send_byte(8'h00, 1'b0);
    send_byte({HI_PITCH, 4'h0}, 1'b0);
    send_byte(BYTE_TICK, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h85, 1'b0);   // non-mode status byte runs as data
    send_byte(8'h40, 1'b0);
    send_delta(496, 1'b0);    // delta dropped by end of track
    send_byte(BYTE_END, 1'b0);
    send_byte(8'h12, 1'b0);   // finished: ignored
    send_byte({HI_NOTE_ON, 4'h0}, 1'b0);
    wait_idle();
  endtask

  task automatic test_delta_groups();
    int unsigned ticks[6];
    ticks = '{0, 127, 128, 16383, 16384, 239};
    foreach (ticks[i]) begin
      send_delta(ticks[i], i == 0);
      send_byte({HI_CONTROL, voice_ch}, 1'b0);
      send_byte(8'(i), 1'b0);
      send_byte(8'h7F, 1'b0);
    end
    wait_idle();
  endtask

  task automatic test_stream_errors();
    send_byte(8'h00, 1'b1);
    send_byte(8'h40, 1'b0);   // data with no mode
    send_byte({HI_NOTE_ON, voice_ch}, 1'b0);  // failed: ignored
    send_byte(8'h00, 1'b1);
    send_byte({HI_NOTE_ON, voice_ch + 4'd1}, 1'b0);  // wrong channel
    send_byte(8'h00, 1'b1);
    send_byte(8'hA5, 1'b0);   // non-mode status, no mode yet
    send_byte(8'h03, 1'b1);
    send_byte({HI_NOTE_ON, voice_ch}, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h05, 1'b1);   // restart mid-event
    send_byte(8'h3C, 1'b0);   // running mode cleared
    send_byte(8'h00, 1'b1);
    send_byte(BYTE_END, 1'b0);
    wait_idle();
  endtask

  task automatic test_channel_settings();
    logic [3:0] chans[3];
    chans = '{4'd15, 4'd7, 4'd0};
    foreach (chans[i]) begin
      write_channel(chans[i]);
      send_byte(8'h01, 1'b1);
      send_byte({HI_NOTE_ON, chans[i]}, 1'b0);
      send_byte(8'h40, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte({HI_CONTROL, chans[i] ^ 4'h5}, 1'b0);
    end
    wait_idle();
  endtask

  task automatic test_output_hold_off();
    write_channel(4'($urandom_range(0, 15)));
    jitter_on = 1'b0;
    hold_cycles = 300;
    send_random_event(1'b1);
    repeat (15) send_random_event(1'b0);
    wait_idle();
    jitter_on = 1'b1;
  endtask

  task automatic test_random_streams();
    int unsigned goal;
    int r;
    for (int p = 0; p < 4; p++) begin
      write_channel(4'($urandom_range(0, 15)));
      jitter_on = (p != 2);
      goal = live_items + RANDOM_ITEMS / 4;
      send_random_event(1'b1);
      while (live_items < goal) begin
        r = $urandom_range(0, 99);
        if (strm_phase == PH_DONE || strm_phase == PH_FAIL || r < 2)
          send_random_event(1'b1);
        else if (r < 8)
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        else
          send_random_event(1'b0);
      end
      wait_idle();
    end
    jitter_on = 1'b1;
  endtask

  initial begin
    int guard;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_event_kinds();
    test_delta_groups();
    test_stream_errors();
    test_channel_settings();
    test_output_hold_off();
    test_random_streams();
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (track_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && track_q.size() == 0)
      $display("packed_midi_to_smf_track_transcoder_tb OK");
    else
      $display("packed_midi_to_smf_track_transcoder_tb NOT OK");
    $finish;
  end

endmodule
